// File: sv/lkvc_pkg.sv
package lkvc_pkg;

  // Configuration register file
  localparam int unsigned CAP_BITS   = 5;
  localparam int unsigned ADDR_BITS  = 3;
  localparam int unsigned DATA_BITS  = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_index_e;

  // Operation code of an input item
  typedef enum logic [0:0] {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_e;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // Update command broadcast from the sequencer to every cell
  typedef struct packed {
    logic upd;    // apply the item this cycle
    logic put;    // item is a put
    logic hit;    // key was found
    logic evict;  // new key replaces the least recent entry
  } cell_ctrl_t;

endpackage

// File: sv/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement,
// built as a row of ENTRIES cells, one per entry. An item is a get (mode 0)
// or a put (mode 1) and always yields one result. While the sequencer is idle
// every cell compares its key against the item and the lookup chain through
// the row settles hit, stored value, recency rank and the least recent key;
// the accepting edge captures this summary. In the update state every cell
// applies its own rank and data update and the result is loaded into the
// output register. A result still waiting at the output delays the update
// until it is taken. The capacity register (address 0) limits the entries
// in use: zero acts as one, values above ENTRIES act as ENTRIES, and lowering
// it does not drop entries, later puts of new keys evict one entry each instead.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic signed [VALUE_BITS:0]   read_value_o,
  output logic                         evicted_o,
  output logic [KEY_BITS-1:0]          evicted_key_o
);

  localparam int unsigned RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_BITS  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

  state_e                state_q, state_d;
  logic [CAP_BITS-1:0]   cap_q;
  logic [OCC_BITS-1:0]   occ_q, occ_d;
  logic                  accept, upd, load_out;
  reg_index_e            reg_idx;

  logic                  put_q, hit_q, evict_q;
  logic [KEY_BITS-1:0]   key_q, lru_key_q;
  logic [VALUE_BITS-1:0] value_q, hit_value_q;
  logic [RANK_BITS-1:0]  hit_rank_q;

  logic                  out_valid_q;
  logic                  out_hit_q, out_evicted_q;
  logic [VALUE_BITS:0]   out_read_q;
  logic [KEY_BITS-1:0]   out_evkey_q;

  logic [CMP_BITS-1:0]   cap_ext, eff_cap;
  logic                  evict_d;
  logic [RANK_BITS-1:0]  lru_rank;
  logic [OCC_BITS-1:0]   occ_m1;
  cell_ctrl_t            ctrl;

  // chain wires, one more than cells
  logic                  free_ch  [ENTRIES+1];
  logic                  hit_ch   [ENTRIES+1];
  logic [VALUE_BITS-1:0] val_ch   [ENTRIES+1];
  logic [RANK_BITS-1:0]  rank_ch  [ENTRIES+1];
  logic [KEY_BITS-1:0]   lkey_ch  [ENTRIES+1];

  // Configuration register
  assign reg_idx = reg_index_e'(paddr[ADDR_BITS-1]);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_CAPACITY) ? DATA_BITS'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_BITS-1:0];
    end
  end

  // Effective capacity and eviction decision
  assign cap_ext = CMP_BITS'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
      eff_cap = CMP_BITS'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign evict_d  = (CMP_BITS'(occ_q) >= eff_cap) && (occ_q != '0);
  assign occ_m1   = occ_q - OCC_BITS'(1);
  assign lru_rank = occ_m1[RANK_BITS-1:0];

  // Handshakes
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = !out_valid_q || out_ready_i;
  assign upd        = (state_q == ST_UPDATE) && load_out;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Occupancy grows only on an insert without eviction
  always_comb begin
    occ_d = occ_q;
    if (upd && put_q && !hit_q && !evict_q) begin
      occ_d = occ_q + OCC_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (upd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item and the lookup summary
  always_ff @(posedge clk_i) begin
    if (accept) begin
      put_q       <= (mode_e'(mode_i) == MODE_PUT);
      key_q       <= key_i;
      value_q     <= value_i;
      hit_q       <= hit_ch[ENTRIES];
      hit_value_q <= val_ch[ENTRIES];
      hit_rank_q  <= rank_ch[ENTRIES];
      lru_key_q   <= lkey_ch[ENTRIES];
      evict_q     <= evict_d;
    end
  end

  // Build the result
  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_hit_q     <= hit_q;
      out_evicted_q <= put_q && !hit_q && evict_q;
      out_evkey_q   <= (put_q && !hit_q && evict_q) ? lru_key_q : '0;
      if (put_q) begin
        out_read_q <= '0;
      end else if (hit_q) begin
        out_read_q <= {1'b0, hit_value_q};
      end else begin
        out_read_q <= '1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign read_value_o  = $signed(out_read_q);
  assign evicted_o     = out_evicted_q;
  assign evicted_key_o = out_evkey_q;

  // Update command to the row
  assign ctrl.upd   = upd;
  assign ctrl.put   = put_q;
  assign ctrl.hit   = hit_q;
  assign ctrl.evict = evict_q;

  // Row of entry cells
  assign free_ch[0] = 1'b0;
  assign hit_ch[0]  = 1'b0;
  assign val_ch[0]  = '0;
  assign rank_ch[0] = '0;
  assign lkey_ch[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_BITS  (RANK_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .look_i         (accept),
      .key_i          (key_i),
      .lru_rank_i     (lru_rank),
      .ctrl_i         (ctrl),
      .wr_key_i       (key_q),
      .wr_value_i     (value_q),
      .hit_rank_i     (hit_rank_q),
      .free_seen_i    (free_ch[g]),
      .hit_i          (hit_ch[g]),
      .hit_value_i    (val_ch[g]),
      .hit_rank_acc_i (rank_ch[g]),
      .lru_key_i      (lkey_ch[g]),
      .free_seen_o    (free_ch[g+1]),
      .hit_o          (hit_ch[g+1]),
      .hit_value_o    (val_ch[g+1]),
      .hit_rank_acc_o (rank_ch[g+1]),
      .lru_key_o      (lkey_ch[g+1])
    );
  end

endmodule

// File: sv/lkvc_cell.sv
module lkvc_cell import lkvc_pkg::*; #(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 20,
  parameter int unsigned RANK_BITS  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // lookup, evaluated on the input ports while idle
  input  logic                  look_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [RANK_BITS-1:0]  lru_rank_i,
  // update broadcast
  input  cell_ctrl_t            ctrl_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic [RANK_BITS-1:0]  hit_rank_i,
  // chain from the previous cell
  input  logic                  free_seen_i,
  input  logic                  hit_i,
  input  logic [VALUE_BITS-1:0] hit_value_i,
  input  logic [RANK_BITS-1:0]  hit_rank_acc_i,
  input  logic [KEY_BITS-1:0]   lru_key_i,
  // chain to the next cell
  output logic                  free_seen_o,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] hit_value_o,
  output logic [RANK_BITS-1:0]  hit_rank_acc_o,
  output logic [KEY_BITS-1:0]   lru_key_o
);

  logic                  valid_q, valid_d;
  logic [RANK_BITS-1:0]  rank_q, rank_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  match_q, lru_q, first_free_q;
  logic                  match, lru, target;

  // Compare this entry against the incoming item
  assign match = valid_q && (key_q == key_i);
  assign lru   = valid_q && (rank_q == lru_rank_i);

  // Fold this entry into the chain
  assign free_seen_o    = free_seen_i | ~valid_q;
  assign hit_o          = hit_i | match;
  assign hit_value_o    = hit_value_i | (match ? value_q : '0);
  assign hit_rank_acc_o = hit_rank_acc_i | (match ? rank_q : '0);
  assign lru_key_o      = lru_key_i | (lru ? key_q : '0);

  // Slot that takes a new key
  assign target = ctrl_i.evict ? lru_q : first_free_q;

  // Next entry state
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.upd) begin
      if (ctrl_i.hit) begin
        if (match_q) begin
          rank_d = '0;
          if (ctrl_i.put) begin
            value_d = wr_value_i;
          end
        end else if (valid_q && (rank_q < hit_rank_i)) begin
          rank_d = rank_q + 1'b1;
        end
      end else if (ctrl_i.put) begin
        if (target) begin
          valid_d = 1'b1;
          rank_d  = '0;
          key_d   = wr_key_i;
          value_d = wr_value_i;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
    end
  end

  // Hold valid mark, rank and the lookup flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      rank_q       <= '0;
      match_q      <= 1'b0;
      lru_q        <= 1'b0;
      first_free_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      if (look_i) begin
        match_q      <= match;
        lru_q        <= lru;
        first_free_q <= ~valid_q & ~free_seen_i;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

// File: test/tb_lru_key_value_cache.sv
module tb_lru_key_value_cache import lkvc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 20;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W:0]   read_value;
    logic                    evicted;
    logic [KEY_W-1:0]        evicted_key;
  } cache_reply_t;

  // Mirror of the cache contents; predicts one reply per accepted item
  class cache_scoreboard;
    logic [KEY_W-1:0] slot_key   [SLOTS];
    logic [VAL_W-1:0] slot_value [SLOTS];
    bit               slot_valid [SLOTS];
    int unsigned      slot_rank  [SLOTS];
    int unsigned      fill;
    int unsigned      capacity;
    cache_reply_t     replies_due[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      capacity = CAP_RESET;
      fill = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_rank[i] = 0;
      end
    endfunction

    function void set_capacity(int unsigned cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // Move slot s to the front; everything more recent ages by one
    function void promote(int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[s] = 0;
    endfunction

    function void note_request(mode_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      int found;
      int slot;
      int oldest;
      int unsigned limit;
      cache_reply_t want;
      found = -1;
      slot = -1;
      oldest = -1;
      want = '0;
      limit = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
      for (int i = 0; i < SLOTS; i++) begin
        if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      end
      if (op == MODE_GET) begin
        if (found >= 0) begin
          want.hit = 1'b1;
          want.read_value = {1'b0, slot_value[found]};
          promote(found);
        end else begin
          want.read_value = (VAL_W+1)'(-1);
        end
      end else if (found >= 0) begin
        want.hit = 1'b1;
        slot_value[found] = value;
        promote(found);
      end else begin
        // Evict the least recent entry when the store is full
        if (fill >= limit && fill > 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) oldest = i;
          end
          want.evicted = 1'b1;
          want.evicted_key = slot_key[oldest];
          slot_valid[oldest] = 1'b0;
          slot_rank[oldest] = 0;
          fill--;
          slot = oldest;
        end
        // Otherwise take the lowest free slot
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_key[slot] = key;
        slot_value[slot] = value;
        slot_valid[slot] = 1'b1;
        slot_rank[slot] = 0;
        fill++;
      end
      replies_due.push_back(want);
    endfunction

    function void check_reply(cache_reply_t got);
      cache_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: hit=%0d read_value=%0d evicted=%0d evicted_key=%h",
                   got.hit, got.read_value, got.evicted, got.evicted_key);
        return;
      end
      want = replies_due.pop_front();
      if (got.hit !== want.hit || got.read_value !== want.read_value ||
          got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: expected hit=%0d read_value=%0d evicted=%0d evicted_key=%h",
                   want.hit, want.read_value, want.evicted, want.evicted_key,
                   ", got hit=%0d read_value=%0d evicted=%0d evicted_key=%h",
                   got.hit, got.read_value, got.evicted, got.evicted_key);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_BITS-1:0]   paddr = '0;
  logic [DATA_BITS-1:0]   pwdata = '0;
  logic [DATA_BITS-1:0]   prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   mode = 1'b0;
  logic [KEY_W-1:0]       key = '0;
  logic [VAL_W-1:0]       value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   hit;
  logic signed [VAL_W:0]  read_value;
  logic                   evicted;
  logic [KEY_W-1:0]       evicted_key;

  cache_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  int unsigned quiet_cycles = 0;
  logic [KEY_W-1:0] key_pool [24];

  lru_key_value_cache #(
    .ENTRIES   (SLOTS),
    .KEY_BITS  (KEY_W),
    .VALUE_BITS(VAL_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .key_i        (key),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hit_o        (hit),
    .read_value_o (read_value),
    .evicted_o    (evicted),
    .evicted_key_o(evicted_key)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stall the result side on its own pattern, with long free-running stretches
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (free_left != 0) begin
      free_left <= free_left - 1;
      out_ready <= 1'b1;
    end else begin
      stall_left <= $urandom_range(0, 12);
      free_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 6);
      out_ready <= 1'b0;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_reply('{hit, read_value, evicted, evicted_key});
  end

  // Count cycles without progress on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("lru_key_value_cache verification failed");
    $finish;
  end

  // Offer one item, opening a new burst after a random gap when due
  task automatic send_item(mode_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    mode <= op;
    key <= k;
    value <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_request(op, k, v);
    burst_left--;
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned cap);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(4 * int'(REG_CAPACITY));
    pwdata <= DATA_BITS'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_capacity(cap);
  endtask

  // Mostly keys from a small pool so hits and evictions are frequent
  task automatic random_phase(int unsigned cap, int unsigned count);
    int unsigned pool_n;
    logic [KEY_W-1:0] k;
    write_capacity(cap);
    pool_n = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap) + 4;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                      : key_pool[$urandom_range(0, pool_n - 1)];
      send_item(($urandom_range(0, 1) == 0) ? MODE_GET : MODE_PUT, k, VAL_W'($urandom));
    end
  endtask

  initial begin
    int unsigned caps [10] = '{1, 0, 3, 31, 2, 16, 17, 5, 4, 12};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store, extreme keys and values, update in place
    send_item(MODE_GET, 16'h0000, 20'h00000);
    send_item(MODE_PUT, 16'h0000, 20'h00000);
    send_item(MODE_PUT, 16'hffff, 20'hfffff);
    send_item(MODE_GET, 16'hffff, 20'h00000);
    send_item(MODE_GET, 16'h0000, 20'hfffff);
    send_item(MODE_PUT, 16'h0000, 20'h5a5a5);
    send_item(MODE_GET, 16'h1234, 20'h00000);
    send_item(MODE_GET, 16'h0000, 20'h00000);

    // Shrink below occupancy, then evict the least recent on each new key
    write_capacity(1);
    send_item(MODE_PUT, 16'h00a1, 20'h11111);
    send_item(MODE_GET, 16'hffff, 20'h00000);
    send_item(MODE_PUT, 16'h00b2, 20'h22222);
    send_item(MODE_GET, 16'h00b2, 20'h00000);
    send_item(MODE_PUT, 16'h00c3, 20'h33333);
    send_item(MODE_GET, 16'h00a1, 20'h00000);
    send_item(MODE_PUT, 16'h00b2, 20'haaaaa);

    foreach (caps[i]) random_phase(caps[i], 66);
    drain();
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

endmodule
